@@ src/sswc_pkg.sv @@
`timescale 1ns / 1ps

package sswc_pkg;

   localparam int MAX_PATTERN   = 16;
   localparam int POSITION_BITS = 16;
   localparam int LEN_BITS      = $clog2(MAX_PATTERN + 1);
   localparam int IDX_BITS      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int START_BITS    = 16;
   localparam int WORD_BITS     = 64;
   localparam int CSR_IDX_BITS  = 2;

   localparam logic [7:0] WILDCARD_CHAR = 8'h3F;
   localparam logic [7:0] LOWER_A       = 8'h61;
   localparam logic [7:0] LOWER_Z       = 8'h7A;
   localparam logic [7:0] CASE_OFFSET   = 8'h20;

   localparam logic [CSR_IDX_BITS-1:0] REG_PATTERN_LOW    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_PATTERN_HIGH   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_PATTERN_LENGTH = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_MATCH_MODE     = 2'd3;

   localparam int MODE_NOCASE_BIT = 0;
   localparam int MODE_WILD_BIT   = 1;

   typedef logic [MAX_PATTERN-1:0][7:0] window_type;

   typedef struct packed {
      logic [2*WORD_BITS-1:0] pattern;
      logic [LEN_BITS-1:0]    length;
      logic [1:0]             mode;
   } cfg_type;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      if (c >= LOWER_A && c <= LOWER_Z) begin
         return c - CASE_OFFSET;
      end
      return c;
   endfunction

endpackage

@@ src/sswc_ifs.sv @@
`timescale 1ns / 1ps

interface sswc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       last_byte;
   modport source(output valid, output text_byte, output last_byte, input ready);
   modport sink(input valid, input text_byte, input last_byte, output ready);
endinterface

interface sswc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             found;
   logic [sswc_pkg::START_BITS-1:0]  match_start;
   logic                             text_done;
   modport source(output valid, output found, output match_start, output text_done,
                  input ready);
   modport sink(input valid, input found, input match_start, input text_done,
                output ready);
endinterface

interface sswc_csr_if;
   logic                               valid;
   logic                               ready;
   logic [sswc_pkg::CSR_IDX_BITS-1:0]  index;
   logic [sswc_pkg::WORD_BITS-1:0]     data;
   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

@@ src/sswc_match.sv @@
`timescale 1ns / 1ps

module sswc_match (
   input  sswc_pkg::cfg_type    cfg,
   input  sswc_pkg::window_type window,
   output logic                 hit
);

   logic [sswc_pkg::MAX_PATTERN-1:0] lane_ok;

   always_comb begin
      logic [sswc_pkg::LEN_BITS-1:0] back;
      logic [7:0]                    p;
      logic [7:0]                    t;
      for (int i = 0; i < sswc_pkg::MAX_PATTERN; i++) begin
         back = cfg.length - sswc_pkg::LEN_BITS'(i) - sswc_pkg::LEN_BITS'(1);
         p    = cfg.pattern[8*i +: 8];
         t    = window[back[sswc_pkg::IDX_BITS-1:0]];
         if (sswc_pkg::LEN_BITS'(i) >= cfg.length) begin
            lane_ok[i] = 1'b1;
         end else if (cfg.mode[sswc_pkg::MODE_WILD_BIT] && p == sswc_pkg::WILDCARD_CHAR) begin
            lane_ok[i] = 1'b1;
         end else if (cfg.mode[sswc_pkg::MODE_NOCASE_BIT]) begin
            lane_ok[i] = (sswc_pkg::fold_case(p) == sswc_pkg::fold_case(t));
         end else begin
            lane_ok[i] = (p == t);
         end
      end
   end

   assign hit = &lane_ok;

endmodule

@@ src/substring_search_wildcard_case_top.sv @@
`timescale 1ns / 1ps

// Streaming leftmost substring search over a byte stream.
// Each word on req_bus carries one text byte and a flag that marks the last
// byte of the text. Each accepted word yields exactly one word on rsp_bus:
// whether a full pattern occurrence has ended so far, the start index of the
// first occurrence, and an echo of the last flag.
// The pattern, its length and the match mode are set through csr_bus, which
// is always ready; they should be written only while no text is in flight.
// A word accepted into the input register passes the compare logic, and
// its result is loaded into the output register once that register is
// free, so a stall on rsp_bus can hold the result back.
// The block takes one word every cycle while rsp_bus accepts its results,
// with a single compare of the 16-byte window against the pattern.
// When rsp_bus stalls, the output register holds its word and the input
// register holds one more word, after which req_bus.ready drops.
// Reset clears the pipeline, the search state and all configuration
// registers. After the last byte of a text, the search state clears for
// the next text.
module substring_search_wildcard_case_top (
   input logic         clock,
   input logic         reset,
   sswc_req_if.sink    req_bus,
   sswc_rsp_if.source  rsp_bus,
   sswc_csr_if.sink    csr_bus
);

   // Configuration registers.
   logic [sswc_pkg::WORD_BITS-1:0] pat_low_ff;
   logic [sswc_pkg::WORD_BITS-1:0] pat_high_ff;
   logic [sswc_pkg::LEN_BITS-1:0]  pat_len_ff;
   logic [1:0]                     mode_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= '0;
         mode_ff     <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            sswc_pkg::REG_PATTERN_LOW:    pat_low_ff  <= csr_bus.data;
            sswc_pkg::REG_PATTERN_HIGH:   pat_high_ff <= csr_bus.data;
            sswc_pkg::REG_PATTERN_LENGTH: pat_len_ff  <= csr_bus.data[sswc_pkg::LEN_BITS-1:0];
            sswc_pkg::REG_MATCH_MODE:     mode_ff     <= csr_bus.data[1:0];
            default: ;
         endcase
      end
   end

   sswc_pkg::cfg_type cfg;

   always_comb begin
      cfg.pattern = {pat_high_ff, pat_low_ff};
      cfg.mode    = mode_ff;
      if (pat_len_ff > sswc_pkg::LEN_BITS'(sswc_pkg::MAX_PATTERN)) begin
         cfg.length = sswc_pkg::LEN_BITS'(sswc_pkg::MAX_PATTERN);
      end else begin
         cfg.length = pat_len_ff;
      end
   end

   // Input register and output register handshakes.
   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;
   logic       rsp_valid_ff;
   logic       rsp_found_ff;
   logic [sswc_pkg::START_BITS-1:0] rsp_start_ff;
   logic       rsp_done_ff;

   logic out_free;
   logic fire;
   logic req_take;

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign fire          = s1_valid_ff && out_free;
   assign req_bus.ready = !s1_valid_ff || out_free;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_bus.text_byte;
         s1_last_ff <= req_bus.last_byte;
      end
   end

   // Search state.
   logic [sswc_pkg::MAX_PATTERN-2:0][7:0]  recent_ff;
   logic [sswc_pkg::MAX_PATTERN-2:0][7:0]  recent_in;
   logic [sswc_pkg::POSITION_BITS-1:0]     pos_ff;
   logic [sswc_pkg::POSITION_BITS-1:0]     pos_in;
   logic                                   found_ff;
   logic                                   found_in;
   logic [sswc_pkg::POSITION_BITS-1:0]     start_ff;
   logic [sswc_pkg::POSITION_BITS-1:0]     start_in;

   sswc_pkg::window_type window;
   logic                 hit;
   logic                 found_now;
   logic [sswc_pkg::POSITION_BITS-1:0] start_now;
   logic [sswc_pkg::POSITION_BITS-1:0] len_minus_one;

   always_comb begin
      window[0] = s1_byte_ff;
      for (int k = 1; k < sswc_pkg::MAX_PATTERN; k++) begin
         window[k] = recent_ff[k-1];
      end
   end

   sswc_match u_match (
      .cfg    (cfg),
      .window (window),
      .hit    (hit)
   );

   assign len_minus_one = sswc_pkg::POSITION_BITS'(cfg.length)
                          - sswc_pkg::POSITION_BITS'(1);

   always_comb begin
      found_now = found_ff;
      start_now = start_ff;
      if (!found_ff) begin
         if (cfg.length == '0) begin
            found_now = 1'b1;
            start_now = '0;
         end else if (pos_ff >= len_minus_one && hit) begin
            found_now = 1'b1;
            start_now = pos_ff - len_minus_one;
         end
      end
   end

   always_comb begin
      recent_in = recent_ff;
      pos_in    = pos_ff;
      found_in  = found_ff;
      start_in  = start_ff;
      if (fire) begin
         if (s1_last_ff) begin
            recent_in = '0;
            pos_in    = '0;
            found_in  = 1'b0;
            start_in  = '0;
         end else begin
            recent_in = {recent_ff[sswc_pkg::MAX_PATTERN-3:0], s1_byte_ff};
            if (pos_ff != '1) begin
               pos_in = pos_ff + sswc_pkg::POSITION_BITS'(1);
            end
            found_in = found_now;
            start_in = start_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff <= '0;
         pos_ff    <= '0;
         found_ff  <= 1'b0;
         start_ff  <= '0;
      end else begin
         recent_ff <= recent_in;
         pos_ff    <= pos_in;
         found_ff  <= found_in;
         start_ff  <= start_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_found_ff <= found_now;
         rsp_start_ff <= found_now ? sswc_pkg::START_BITS'(start_now) : '0;
         rsp_done_ff  <= s1_last_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.found       = rsp_found_ff;
   assign rsp_bus.match_start = rsp_start_ff;
   assign rsp_bus.text_done   = rsp_done_ff;

   // Assertions.
   a_start_zero_unless_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_start_ff == '0)
      else $error("match_start nonzero while found is low");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      fire && s1_last_ff |=> pos_ff == '0 && !found_ff && start_ff == '0)
      else $error("search state not cleared after the last byte");

   a_found_sticky: assert property (@(posedge clock) disable iff (reset)
      found_ff && !(fire && s1_last_ff) |=> found_ff)
      else $error("found dropped within a text");

   a_take_fills_input: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted word missing from the input register");

endmodule

@@ bench/tb_substring_search_wildcard_case_top.sv @@
`timescale 1ns / 1ps

module tb_substring_search_wildcard_case_top;
   import sswc_pkg::*;

   localparam int STALL_LIMIT     = 2000;
   localparam int RANDOM_PHASES   = 16;
   localparam int WORDS_PER_PHASE = 34;
   localparam int NORMAL_IDLE_PCT = 20;

   localparam logic [1:0] MODE_EXACT       = 2'd0;
   localparam logic [1:0] MODE_NOCASE      = 2'd1;
   localparam logic [1:0] MODE_WILD        = 2'd2;
   localparam logic [1:0] MODE_WILD_NOCASE = 2'd3;

   localparam logic [7:0] TEXT_ALPHABET [12] = '{
      8'h61, 8'h62, 8'h7A, 8'h41, 8'h42, 8'h5A, 8'h3F, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h63
   };

   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
   } text_word_type;

   typedef struct packed {
      logic                  found;
      logic [START_BITS-1:0] start;
      logic                  done;
   } match_report_type;

   logic clock;
   logic reset;

   sswc_req_if req_bus();
   sswc_rsp_if rsp_bus();
   sswc_csr_if csr_bus();

   substring_search_wildcard_case_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   logic [63:0]              cfg_pattern_lo;
   logic [63:0]              cfg_pattern_hi;
   logic [4:0]               cfg_length;
   logic [1:0]               cfg_mode;
   logic [7:0]               window_bytes [MAX_PATTERN-1];
   logic [POSITION_BITS-1:0] next_index;
   logic                     match_seen;
   logic [POSITION_BITS-1:0] match_origin;

   text_word_type    pending_words [$];
   match_report_type expected_reports [$];
   text_word_type    next_word;
   match_report_type want;

   int queued_words;
   int taken_words;
   int errors;
   int quiet_cycles;
   int send_idle_pct;
   int take_idle_pct;

   always #5 clock = ~clock;

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) ? {c[7:6], 1'b0, c[4:0]} : c;
   endfunction

   function automatic logic chars_agree(input logic [7:0] p, input logic [7:0] t);
      if (cfg_mode[MODE_WILD_BIT] && p == WILDCARD_CHAR) begin
         return 1'b1;
      end
      if (cfg_mode[MODE_NOCASE_BIT]) begin
         return to_upper(p) == to_upper(t);
      end
      return p == t;
   endfunction

   function automatic int effective_length();
      return (cfg_length > MAX_PATTERN) ? MAX_PATTERN : int'(cfg_length);
   endfunction

   function automatic void clear_search();
      foreach (window_bytes[k]) begin
         window_bytes[k] = 8'h00;
      end
      next_index   = '0;
      match_seen   = 1'b0;
      match_origin = '0;
   endfunction

   function automatic match_report_type search_step(input logic [7:0] cur, input logic fin);
      int                len;
      int                back;
      int                i;
      logic              ok;
      logic [7:0]        t;
      logic [127:0]      pat;
      match_report_type  r;
      len = effective_length();
      pat = {cfg_pattern_hi, cfg_pattern_lo};
      if (!match_seen) begin
         if (len == 0) begin
            match_seen   = 1'b1;
            match_origin = '0;
         end else if (next_index >= len - 1) begin
            ok = 1'b1;
            for (i = 0; i < len; i++) begin
               back = len - 1 - i;
               t = (back == 0) ? cur : window_bytes[back-1];
               if (!chars_agree(pat[8*i +: 8], t)) begin
                  ok = 1'b0;
               end
            end
            if (ok) begin
               match_seen   = 1'b1;
               match_origin = POSITION_BITS'(next_index - (len - 1));
            end
         end
      end
      r.found = match_seen;
      r.start = match_seen ? match_origin[START_BITS-1:0] : '0;
      r.done  = fin;
      if (fin) begin
         clear_search();
      end else begin
         for (i = MAX_PATTERN - 2; i > 0; i--) begin
            window_bytes[i] = window_bytes[i-1];
         end
         window_bytes[0] = cur;
         if (next_index != {POSITION_BITS{1'b1}}) begin
            next_index = next_index + 1'b1;
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] pick_text_char();
      if ($urandom_range(99) < 70) begin
         return TEXT_ALPHABET[$urandom_range(11)];
      end
      return 8'($urandom_range(255, 1));
   endfunction

   function automatic logic [7:0] pick_pattern_char();
      if ($urandom_range(99) < 65) begin
         return TEXT_ALPHABET[$urandom_range(11)];
      end
      return 8'($urandom_range(255));
   endfunction

   function automatic void queue_word(input logic [7:0] ch, input logic fin);
      text_word_type w;
      w.ch  = ch;
      w.fin = fin;
      pending_words.push_back(w);
      queued_words++;
   endfunction

   function automatic void queue_text(input string s, input logic ends);
      for (int i = 0; i < s.len(); i++) begin
         queue_word(s[i], ends && (i == s.len() - 1));
      end
   endfunction

   // Builds one text and often plants a pattern occurrence in it, with case flips and
   // wildcard positions filled in as the current mode allows.
   function automatic int queue_random_text();
      logic [7:0]   chars [$];
      logic [127:0] pat;
      logic [7:0]   p;
      logic [7:0]   c;
      int           span;
      int           len;
      int           at;
      span = ($urandom_range(99) < 10) ? $urandom_range(80, 30) : $urandom_range(20, 1);
      len  = effective_length();
      pat  = {cfg_pattern_hi, cfg_pattern_lo};
      for (int i = 0; i < span; i++) begin
         chars.push_back(pick_text_char());
      end
      if (len > 0 && len <= span && $urandom_range(99) < 60) begin
         at = $urandom_range(span - len);
         for (int i = 0; i < len; i++) begin
            p = pat[8*i +: 8];
            c = p;
            if (cfg_mode[MODE_WILD_BIT] && p == WILDCARD_CHAR) begin
               c = pick_text_char();
            end else if (cfg_mode[MODE_NOCASE_BIT] && $urandom_range(1) == 1
                         && to_upper(p) >= 8'h41 && to_upper(p) <= 8'h5A) begin
               c = p ^ CASE_OFFSET;
            end
            if (c == 8'h00) begin
               c = pick_text_char();
            end
            chars[at+i] = c;
         end
      end
      for (int i = 0; i < span; i++) begin
         queue_word(chars[i], i == span - 1);
      end
      return span;
   endfunction

   task automatic load_search_config(input logic [63:0] lo, input logic [63:0] hi,
                                     input logic [4:0] len, input logic [1:0] mode);
      logic [CSR_IDX_BITS-1:0] reg_index [4];
      logic [63:0]             reg_value [4];
      reg_index = '{REG_PATTERN_LOW, REG_PATTERN_HIGH, REG_PATTERN_LENGTH, REG_MATCH_MODE};
      reg_value = '{lo, hi, 64'(len), 64'(mode)};
      @(posedge clock);
      for (int k = 0; k < 4; k++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= reg_index[k];
         csr_bus.data  <= reg_value[k];
         @(posedge clock);
         while (!csr_bus.ready) begin
            @(posedge clock);
         end
         case (reg_index[k])
            REG_PATTERN_LOW: begin
               cfg_pattern_lo = reg_value[k];
            end
            REG_PATTERN_HIGH: begin
               cfg_pattern_hi = reg_value[k];
            end
            REG_PATTERN_LENGTH: begin
               cfg_length = reg_value[k][4:0];
            end
            default: begin
               cfg_mode = reg_value[k][1:0];
            end
         endcase
      end
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_random_config(input int phase);
      logic [127:0] pat;
      logic [4:0]   len;
      logic [1:0]   mode;
      int           r;
      pat  = {$urandom, $urandom, $urandom, $urandom};
      r    = $urandom_range(99);
      mode = (phase < 4) ? 2'(phase) : 2'($urandom_range(3));
      if (phase == 0) begin
         len = 5'd16;
      end else if (phase == 1) begin
         len = 5'd1;
      end else if (r < 4) begin
         len = 5'($urandom_range(31, 17));
      end else if (r < 24) begin
         len = 5'($urandom_range(16));
      end else begin
         len = 5'($urandom_range(6, 1));
      end
      for (int i = 0; i < MAX_PATTERN && i < len; i++) begin
         pat[8*i +: 8] = pick_pattern_char();
      end
      load_search_config(pat[63:0], pat[127:64], len, mode);
   endtask

   task automatic wait_for_drain();
      do begin
         @(negedge clock);
      end while (taken_words != queued_words || expected_reports.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_reports.push_back(search_step(req_bus.text_byte, req_bus.last_byte));
            taken_words++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_word = pending_words.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.text_byte <= next_word.ch;
               req_bus.last_byte <= next_word.fin;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected word found=%0b match_start=%0d text_done=%0b",
                        $time, rsp_bus.found, rsp_bus.match_start, rsp_bus.text_done);
               errors++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_bus.found !== want.found) begin
                  $display("%0t: found expected %0b actual %0b",
                           $time, want.found, rsp_bus.found);
                  errors++;
               end
               if (rsp_bus.match_start !== want.start) begin
                  $display("%0t: match_start expected %0d actual %0d",
                           $time, want.start, rsp_bus.match_start);
                  errors++;
               end
               if (rsp_bus.text_done !== want.done) begin
                  $display("%0t: text_done expected %0b actual %0b",
                           $time, want.done, rsp_bus.text_done);
                  errors++;
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.text_byte = 8'h00;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = '0;
      csr_bus.data      = '0;
      cfg_pattern_lo    = '0;
      cfg_pattern_hi    = '0;
      cfg_length        = '0;
      cfg_mode          = MODE_EXACT;
      queued_words      = 0;
      taken_words       = 0;
      errors            = 0;
      quiet_cycles      = 0;
      send_idle_pct     = NORMAL_IDLE_PCT;
      take_idle_pct     = NORMAL_IDLE_PCT;
      clear_search();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // An empty pattern matches at the first byte of every text.
      load_search_config(64'h0, 64'h0, 5'd0, MODE_EXACT);
      queue_text("xy", 1'b1);
      wait_for_drain();

      // The mode changes in the middle of a text, and the window must survive it.
      load_search_config(64'h633F61, 64'h0, 5'd3, MODE_WILD);
      queue_text("xA", 1'b0);
      wait_for_drain();
      load_search_config(64'h633F61, 64'h0, 5'd3, MODE_WILD_NOCASE);
      queue_text("zc", 1'b1);
      wait_for_drain();

      // Without the wildcard mode a question mark is a literal character.
      load_search_config(64'h633F61, 64'h0, 5'd3, MODE_NOCASE);
      queue_text("A?C", 1'b1);
      wait_for_drain();

      // A length above the maximum is clamped to a full 16-byte pattern.
      load_search_config(64'h01FF01FF01FF01FF, 64'h01FF01FF01FF01FF, 5'd31, MODE_EXACT);
      for (int i = 0; i < MAX_PATTERN; i++) begin
         queue_word((i % 2 == 0) ? 8'hFF : 8'h01, i == MAX_PATTERN - 1);
      end
      wait_for_drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_random_config(phase);
         send_idle_pct = (phase == 5) ? 0 : NORMAL_IDLE_PCT;
         take_idle_pct = (phase == 5) ? 0 : NORMAL_IDLE_PCT;
         for (int n = 0; n < WORDS_PER_PHASE; ) begin
            n += queue_random_text();
         end
         wait_for_drain();
      end

      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
